/* rtl/core/upd_pkg.sv */
package upd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_done;
      logic [1:0] out_status;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_SLASH,
      MODE_PATH,
      MODE_HEX_HI,
      MODE_HEX_LO,
      MODE_REST
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [3:0] high_nibble;
      logic       rejected;
   } state_type;

   localparam state_type STATE_RESET = '{mode: MODE_SLASH, high_nibble: 4'd0, rejected: 1'b0};

   localparam logic [1:0] STATUS_BUSY   = 2'd0;
   localparam logic [1:0] STATUS_ACCEPT = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_PERCENT   = 8'h25;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3f;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   // Bit 4 set means the byte is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = 5'(c - 8'h37);
      end else begin
         d = 5'h10;
      end
      return d;
   endfunction

endpackage

/* rtl/core/upd_step.sv */
module upd_step
   import upd_pkg::*;
(
   input  state_type state,
   input  req_type   req,
   output state_type state_next,
   output rsp_type   rsp
);

   logic [7:0] c;
   logic [4:0] digit;
   logic       ends_path;
   logic       cand_have;
   logic [7:0] cand_byte;
   logic       bad;
   logic       forbidden;
   logic       fail;
   mode_type   mode_adv;
   logic [3:0] nibble_adv;
   logic       rej_adv;
   logic       rej_final;

   assign c         = req.in_byte;
   assign digit     = hex_digit(c);
   assign ends_path = (c == CHAR_QUESTION) || (c == CHAR_HASH);

   // Candidate byte and escape errors for the current mode.
   always_comb begin
      cand_have = 1'b0;
      cand_byte = CHAR_NUL;
      bad       = 1'b0;
      unique case (state.mode)
         MODE_SLASH: begin
            if (c == CHAR_SLASH) begin
               cand_have = 1'b1;
               cand_byte = c;
            end else begin
               bad = 1'b1;
            end
         end
         MODE_PATH: begin
            if (!ends_path && c != CHAR_PERCENT) begin
               cand_have = 1'b1;
               cand_byte = c;
            end
         end
         MODE_HEX_HI: begin
            bad = ends_path || digit[4];
         end
         MODE_HEX_LO: begin
            if (ends_path || digit[4]) begin
               bad = 1'b1;
            end else begin
               cand_have = 1'b1;
               cand_byte = {state.high_nibble, digit[3:0]};
            end
         end
         default: begin
         end
      endcase
   end

   assign forbidden = cand_have && (cand_byte == CHAR_NUL || cand_byte == CHAR_BACKSLASH);
   assign fail      = bad || forbidden;

   // Next state.
   always_comb begin
      mode_adv   = state.mode;
      nibble_adv = state.high_nibble;
      rej_adv    = state.rejected;
      if (fail) begin
         mode_adv = MODE_REST;
         rej_adv  = 1'b1;
      end else begin
         unique case (state.mode)
            MODE_SLASH:  mode_adv = MODE_PATH;
            MODE_PATH: begin
               if (ends_path) begin
                  mode_adv = MODE_REST;
               end else if (c == CHAR_PERCENT) begin
                  mode_adv = MODE_HEX_HI;
               end
            end
            MODE_HEX_HI: begin
               mode_adv   = MODE_HEX_LO;
               nibble_adv = digit[3:0];
            end
            MODE_HEX_LO: mode_adv = MODE_PATH;
            default:     mode_adv = MODE_REST;
         endcase
      end
      if (req.in_last) begin
         state_next = STATE_RESET;
      end else begin
         state_next = '{mode: mode_adv, high_nibble: nibble_adv, rejected: rej_adv};
      end
   end

   // Result item.
   always_comb begin
      rej_final = rej_adv || mode_adv == MODE_HEX_HI || mode_adv == MODE_HEX_LO
                  || mode_adv == MODE_SLASH;
      rsp.out_valid = cand_have && !forbidden && !state.rejected;
      rsp.out_byte  = rsp.out_valid ? cand_byte : CHAR_NUL;
      rsp.out_done  = req.in_last;
      if (!req.in_last) begin
         rsp.out_status = STATUS_BUSY;
      end else if (rej_final) begin
         rsp.out_status = STATUS_REJECT;
      end else begin
         rsp.out_status = STATUS_ACCEPT;
      end
   end

endmodule

/* rtl/core/url_path_percent_decoder.sv */
// A result is valid in the cycle after its byte is transferred in.
// One byte per cycle unless results stall; mode update and decode fit between
// the state registers and the result register, which carry the next byte on.
// Reset (synchronous, active high): mode returns to expecting the leading
// slash, pending nibble and reject flag clear, and the result register empties.
module url_path_percent_decoder
   import upd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      req_fire;

   upd_step u_step (
      .state      (state_ff),
      .req        (req_data),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   // Take a new byte whenever the result register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/upd_checker.sv */
module upd_checker
   import upd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Every input transfer shows up as a result in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_data.out_done == $past(req_data.in_last))
      else $error("input transfer without matching result");

   a_status_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_done |-> rsp_data.out_status == STATUS_BUSY)
      else $error("status given before final byte");

   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_done |->
         rsp_data.out_status == STATUS_ACCEPT || rsp_data.out_status == STATUS_REJECT)
      else $error("final byte without accept or reject");

   // Forbidden bytes never leave the block, and idle results carry zero.
   a_byte_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_valid ?
         (rsp_data.out_byte != CHAR_NUL && rsp_data.out_byte != CHAR_BACKSLASH) :
         (rsp_data.out_byte == CHAR_NUL)))
      else $error("illegal output byte");

endmodule

bind url_path_percent_decoder upd_checker u_upd_checker (.*);
